// ===== src/nlcc_pkg.sv =====
// Shared types, constants and helpers of the NMEA line checksum checker.
package nlcc_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_DOLLAR  = 8'h24;
  localparam byte_t CH_STAR    = 8'h2A;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_NUL     = 8'h00;

  // Sentence classes as reported on the result channel
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_OTHER = 2'd0;
  localparam kind_t KIND_GGA   = 2'd1;
  localparam kind_t KIND_RMC   = 2'd2;
  localparam kind_t KIND_VTG   = 2'd3;

  localparam int unsigned NUM_KINDS  = 3;
  localparam int unsigned PREFIX_LEN = 6;

  // Sentence prefixes; row order matches the match-flag bit order
  localparam byte_t KIND_PREFIX [NUM_KINDS][PREFIX_LEN] = '{
    '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41},  // $GNGGA
    '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},  // $GNRMC
    '{8'h24, 8'h47, 8'h4E, 8'h56, 8'h54, 8'h47}   // $GNVTG
  };

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_BODY  = 6'b000010,
    PH_HEX1  = 6'b000100,
    PH_HEX2  = 6'b001000,
    PH_GOOD  = 6'b010000,
    PH_BAD   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    byte_t                  xor_acc;
    byte_t                  hex1;
    logic [NUM_KINDS-1:0]   kind_match;
  } scan_st_t;

  localparam scan_st_t SCAN_ST_INIT = '{
    phase:      PH_START,
    xor_acc:    8'h00,
    hex1:       8'h00,
    kind_match: {NUM_KINDS{1'b1}}
  };

  typedef struct packed {
    logic  line_valid;
    kind_t sentence_kind;
    byte_t computed_sum;
  } verdict_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic byte_t hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

endpackage

// ===== src/nlcc_in_if.sv =====
// Byte input channel of the NMEA line checksum checker.
interface nlcc_in_if;
  logic              valid;
  logic              ready;
  nlcc_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/nlcc_out_if.sv =====
// Verdict output channel of the NMEA line checksum checker.
interface nlcc_out_if;
  logic              valid;
  logic              ready;
  logic              line_valid;
  nlcc_pkg::kind_t   sentence_kind;
  nlcc_pkg::byte_t   computed_sum;

  modport source (output valid, output line_valid, output sentence_kind,
                  output computed_sum, input ready);
  modport sink   (input valid, input line_valid, input sentence_kind,
                  input computed_sum, output ready);
endinterface

// ===== src/nlcc_step.sv =====
// Per-byte scan step: next line state and the verdict at a line end.
module nlcc_step #(
  parameter int unsigned LINE_STORE_BYTES = 128,
  parameter int unsigned SCAN_LIMIT       = 75,
  parameter int unsigned FILL_W           = $clog2(LINE_STORE_BYTES + 1)
) (
  input  nlcc_pkg::byte_t    rx_byte,
  input  logic [FILL_W-1:0]  fill,
  input  nlcc_pkg::scan_st_t st,
  output nlcc_pkg::scan_st_t st_nxt,
  output logic [FILL_W-1:0]  fill_nxt,
  output logic               line_end,
  output nlcc_pkg::verdict_t verdict
);

  logic in_prefix;

  assign line_end  = (rx_byte == nlcc_pkg::CH_NEWLINE) ||
                     (fill >= FILL_W'(LINE_STORE_BYTES));
  assign in_prefix = (fill >= FILL_W'(1)) && (fill <= FILL_W'(nlcc_pkg::PREFIX_LEN - 1));

  // verdict from the state left by the bytes before the line end
  always_comb begin
    verdict.line_valid    = (st.phase == nlcc_pkg::PH_GOOD);
    verdict.computed_sum  = st.xor_acc;
    verdict.sentence_kind = nlcc_pkg::KIND_OTHER;
    if (verdict.line_valid && (fill >= FILL_W'(nlcc_pkg::PREFIX_LEN))) begin
      priority if (st.kind_match[0]) verdict.sentence_kind = nlcc_pkg::KIND_GGA;
      else if (st.kind_match[1])     verdict.sentence_kind = nlcc_pkg::KIND_RMC;
      else if (st.kind_match[2])     verdict.sentence_kind = nlcc_pkg::KIND_VTG;
      else                           verdict.sentence_kind = nlcc_pkg::KIND_OTHER;
    end
  end

  always_comb begin
    st_nxt   = st;
    fill_nxt = fill + FILL_W'(1);
    if (line_end) begin
      st_nxt   = nlcc_pkg::SCAN_ST_INIT;
      fill_nxt = '0;
    end else begin
      if (in_prefix) begin
        for (int k = 0; k < nlcc_pkg::NUM_KINDS; k++) begin
          if (nlcc_pkg::KIND_PREFIX[k][fill[2:0]] != rx_byte)
            st_nxt.kind_match[k] = 1'b0;
        end
      end
      unique case (st.phase)
        nlcc_pkg::PH_START: begin
          st_nxt.phase = (rx_byte == nlcc_pkg::CH_DOLLAR) ? nlcc_pkg::PH_BODY
                                                          : nlcc_pkg::PH_BAD;
        end
        nlcc_pkg::PH_BODY: begin
          priority if ((fill >= FILL_W'(SCAN_LIMIT)) || (rx_byte == nlcc_pkg::CH_NUL))
            st_nxt.phase = nlcc_pkg::PH_BAD;
          else if (rx_byte == nlcc_pkg::CH_STAR)
            st_nxt.phase = nlcc_pkg::PH_HEX1;
          else
            st_nxt.xor_acc = st.xor_acc ^ rx_byte;
        end
        nlcc_pkg::PH_HEX1: begin
          st_nxt.hex1  = rx_byte;
          st_nxt.phase = nlcc_pkg::PH_HEX2;
        end
        nlcc_pkg::PH_HEX2: begin
          st_nxt.phase =
            ((st.hex1 == nlcc_pkg::hex_digit(st.xor_acc[7:4])) &&
             (rx_byte == nlcc_pkg::hex_digit(st.xor_acc[3:0]))) ? nlcc_pkg::PH_GOOD
                                                                 : nlcc_pkg::PH_BAD;
        end
        nlcc_pkg::PH_GOOD, nlcc_pkg::PH_BAD: begin
          st_nxt.phase = st.phase;  // trailing bytes ignored
        end
        default: begin
          st_nxt.phase = nlcc_pkg::PH_BAD;
        end
      endcase
    end
  end

endmodule

// ===== src/nmea_line_checksum_checker.sv =====
// Top level of the NMEA line checksum checker: input register, scan state, verdict register.
//
// Usage:
//   in_ch  - one received UART byte per word (rx_byte). A newline ends the line; so does
//            any byte that arrives when LINE_STORE_BYTES bytes are already held, and that
//            byte is dropped.
//   out_ch - one verdict word per line end: line_valid, sentence_kind, computed_sum.
//            Other bytes give no word.
// Throughput: one byte per cycle, sustained, unless a line-ending byte waits for out_ch to take the old verdict.
// Path: a line-ending byte goes through the input register, then the verdict register,
//   before its verdict shows on out_ch.
// Stall: a waiting verdict sits in the output register while body bytes keep
//   flowing; only the next line-ending byte waits in the input register, and
//   in_ch.ready drops behind it until out_ch takes the old verdict.
// Reset (rst_n low, synchronous): input and output registers empty, scan state
//   back to "expect '$'" with an empty line.
module nmea_line_checksum_checker #(
  parameter int unsigned LINE_STORE_BYTES = 128,  // 80..255
  parameter int unsigned SCAN_LIMIT       = 75    // 8..78
) (
  input  logic             clk,
  input  logic             rst_n,
  nlcc_in_if.sink          in_ch,
  nlcc_out_if.source       out_ch
);

  localparam int unsigned FILL_W = $clog2(LINE_STORE_BYTES + 1);

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  nlcc_pkg::byte_t    s1_byte_r;

  // line state
  nlcc_pkg::scan_st_t st_r, st_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  // verdict register
  logic               out_valid_r, out_valid_nxt;
  nlcc_pkg::verdict_t out_res_r;

  logic               line_end;
  nlcc_pkg::verdict_t verdict;
  logic               out_free;
  logic               s1_adv;
  logic               in_acc;

  nlcc_step #(
    .LINE_STORE_BYTES (LINE_STORE_BYTES),
    .SCAN_LIMIT       (SCAN_LIMIT),
    .FILL_W           (FILL_W)
  ) u_step (
    .rx_byte  (s1_byte_r),
    .fill     (fill_r),
    .st       (st_r),
    .st_nxt   (st_nxt),
    .fill_nxt (fill_nxt),
    .line_end (line_end),
    .verdict  (verdict)
  );

  // Body bytes always move on; a line end needs room in the verdict register.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!line_end || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && line_end) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= nlcc_pkg::SCAN_ST_INIT;
      fill_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r   <= st_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_byte_r <= in_ch.rx_byte;
    if (s1_adv && line_end) out_res_r <= verdict;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.line_valid    = out_res_r.line_valid;
  assign out_ch.sentence_kind = out_res_r.sentence_kind;
  assign out_ch.computed_sum  = out_res_r.computed_sum;

  // A processed line end always produces a verdict word next cycle.
  a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && line_end) |=> out_ch.valid)
    else $error("line end did not load a verdict");

  // A processed line end restarts the line.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && line_end) |=> (fill_r == '0) && (st_r.phase == nlcc_pkg::PH_START))
    else $error("line state not restarted after line end");

  // The byte count never passes the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LINE_STORE_BYTES))
    else $error("fill count past line store size");

  // An invalid line never carries a sentence class.
  a_kind_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.line_valid) |-> (out_ch.sentence_kind == nlcc_pkg::KIND_OTHER))
    else $error("invalid line classed");

endmodule

// ===== tb/sv/nmea_line_checksum_checker_tb.sv =====
// Self-checking testbench of the NMEA line checksum checker: byte stream in, line verdicts out.
module nmea_line_checksum_checker_tb;

  localparam int unsigned LINE_BYTES   = 128;
  localparam int unsigned SCAN_LIM     = 75;
  localparam int unsigned RANDOM_BYTES = 1750;

  localparam nlcc_pkg::byte_t UPPER_HEX [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                                 "8", "9", "A", "B", "C", "D", "E", "F"};

  // ways to spoil the checksum digits of a generated sentence
  typedef enum int {
    FLAW_NONE,
    FLAW_LOWER,
    FLAW_WRONG,
    FLAW_ONE_DIGIT,
    FLAW_NO_DIGIT
  } flaw_t;

  logic clk;
  logic rst_n;
  logic calm;  // set near the end: no idling on either side

  nlcc_in_if  in_ch ();
  nlcc_out_if out_ch ();

  nmea_line_checksum_checker #(
    .LINE_STORE_BYTES (LINE_BYTES),
    .SCAN_LIMIT       (SCAN_LIM)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Tracks the line scan byte by byte and keeps the verdicts still owed by the block.
  class verdict_board;
    int unsigned                    fill;
    nlcc_pkg::phase_t               phase;
    nlcc_pkg::byte_t                acc;
    nlcc_pkg::byte_t                hex_hi;
    logic [nlcc_pkg::NUM_KINDS-1:0] kmatch;
    nlcc_pkg::verdict_t             due[$];
    int unsigned                    errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      fill   = 0;
      phase  = nlcc_pkg::PH_START;
      acc    = '0;
      hex_hi = '0;
      kmatch = '1;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // called for every accepted input word
    function void note_byte(nlcc_pkg::byte_t b);
      nlcc_pkg::verdict_t v;
      if (b != nlcc_pkg::CH_NEWLINE && fill < LINE_BYTES) begin
        // prefix flags only look at bytes 1..5; byte 0 is judged by the phase
        if (fill >= 1 && fill < nlcc_pkg::PREFIX_LEN) begin
          for (int k = 0; k < nlcc_pkg::NUM_KINDS; k++) begin
            if (nlcc_pkg::KIND_PREFIX[k][fill] != b) kmatch[k] = 1'b0;
          end
        end
        case (phase)
          nlcc_pkg::PH_START: begin
            phase = (b == nlcc_pkg::CH_DOLLAR) ? nlcc_pkg::PH_BODY : nlcc_pkg::PH_BAD;
          end
          nlcc_pkg::PH_BODY: begin
            if (fill >= SCAN_LIM || b == nlcc_pkg::CH_NUL) phase = nlcc_pkg::PH_BAD;
            else if (b == nlcc_pkg::CH_STAR) phase = nlcc_pkg::PH_HEX1;
            else acc ^= b;
          end
          nlcc_pkg::PH_HEX1: begin
            hex_hi = b;
            phase  = nlcc_pkg::PH_HEX2;
          end
          nlcc_pkg::PH_HEX2: begin
            phase = (hex_hi == UPPER_HEX[acc[7:4]] && b == UPPER_HEX[acc[3:0]]) ?
                    nlcc_pkg::PH_GOOD : nlcc_pkg::PH_BAD;
          end
          default: ;
        endcase
        fill++;
      end else begin
        // newline, or any byte hitting a full store: line ends, byte is dropped
        v.line_valid    = (phase == nlcc_pkg::PH_GOOD);
        v.sentence_kind = nlcc_pkg::KIND_OTHER;
        v.computed_sum  = acc;
        if (v.line_valid && fill >= nlcc_pkg::PREFIX_LEN) begin
          if (kmatch[0]) v.sentence_kind = nlcc_pkg::KIND_GGA;
          else if (kmatch[1]) v.sentence_kind = nlcc_pkg::KIND_RMC;
          else if (kmatch[2]) v.sentence_kind = nlcc_pkg::KIND_VTG;
        end
        due.push_back(v);
        restart();
      end
    endfunction

    // called for every accepted result word
    function void check_verdict(logic lv, nlcc_pkg::kind_t kind, nlcc_pkg::byte_t xsum);
      nlcc_pkg::verdict_t exp_v;
      if (due.size() == 0) begin
        $error("verdict with none pending: line_valid %0d kind %0d sum %02h",
               lv, kind, xsum);
        errors++;
        return;
      end
      exp_v = due.pop_front();
      if (lv !== exp_v.line_valid) begin
        $error("line_valid: expected %0d, got %0d", exp_v.line_valid, lv);
        errors++;
      end
      if (kind !== exp_v.sentence_kind) begin
        $error("sentence_kind: expected %0d, got %0d", exp_v.sentence_kind, kind);
        errors++;
      end
      if (xsum !== exp_v.computed_sum) begin
        $error("computed_sum: expected %02h, got %02h", exp_v.computed_sum, xsum);
        errors++;
      end
    endfunction
  endclass

  verdict_board    board;
  nlcc_pkg::byte_t line_buf[$];  // bytes of the line about to be sent
  nlcc_pkg::byte_t body_buf[$];  // sentence body between '$' and '*'
  int unsigned     random_sent;

  function automatic nlcc_pkg::byte_t any_but_newline();
    nlcc_pkg::byte_t b;
    b = nlcc_pkg::byte_t'($urandom_range(0, 255));
    if (b == nlcc_pkg::CH_NEWLINE) b = 8'h8A;
    return b;
  endfunction

  function automatic nlcc_pkg::byte_t to_lower(nlcc_pkg::byte_t c);
    return (c >= "A" && c <= "F") ? c + 8'h20 : c;
  endfunction

  // one word on the input channel, with an occasional idle burst ahead of it
  task automatic send_byte(nlcc_pkg::byte_t b);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(b);
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    random_sent += line_buf.size();
    line_buf.delete();
  endtask

  // hold off the sender until every owed verdict has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic body_text(string s);
    for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
  endtask

  // printable-ish filler, never newline, NUL or '*'
  task automatic filler(int unsigned n);
    nlcc_pkg::byte_t b;
    repeat (n) begin
      b = nlcc_pkg::byte_t'($urandom_range(1, 255));
      if (b == nlcc_pkg::CH_NEWLINE || b == nlcc_pkg::CH_STAR) b ^= 8'h80;
      body_buf.push_back(b);
    end
  endtask

  // '$' + body + '*' + two hex digits (maybe spoiled) + trailing junk + newline
  task automatic put_sentence(flaw_t flaw, int unsigned trail);
    nlcc_pkg::byte_t xsum;
    nlcc_pkg::byte_t hi;
    nlcc_pkg::byte_t lo;
    xsum = '0;
    line_buf.push_back(nlcc_pkg::CH_DOLLAR);
    foreach (body_buf[i]) begin
      line_buf.push_back(body_buf[i]);
      xsum ^= body_buf[i];
    end
    line_buf.push_back(nlcc_pkg::CH_STAR);
    hi = UPPER_HEX[xsum[7:4]];
    lo = UPPER_HEX[xsum[3:0]];
    case (flaw)
      FLAW_NONE: begin
        line_buf.push_back(hi);
        line_buf.push_back(lo);
      end
      FLAW_LOWER: begin
        line_buf.push_back(to_lower(hi));
        line_buf.push_back(to_lower(lo));
      end
      FLAW_WRONG: begin
        line_buf.push_back(hi);
        line_buf.push_back(lo ^ 8'h01);
      end
      FLAW_ONE_DIGIT: line_buf.push_back(hi);
      default: ;
    endcase
    repeat (trail) line_buf.push_back(any_but_newline());
    line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    body_buf.delete();
  endtask

  task automatic directed_lines();
    // empty line
    line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    flush_line();
    // no '$' up front
    body_text("GNGGA,1");
    put_sentence(FLAW_NONE, 0);
    line_buf[0] = "G";
    flush_line();
    // each kind, good checksum
    body_text("GNGGA,123519,4807.038,N");
    put_sentence(FLAW_NONE, 0);
    body_text("GNRMC,A");
    put_sentence(FLAW_NONE, 0);
    body_text("GNVTG");
    put_sentence(FLAW_NONE, 0);
    // "$*00": valid but shorter than a prefix
    put_sentence(FLAW_NONE, 0);
    // near-miss prefix stays kind other
    body_text("GNGGB,1");
    put_sentence(FLAW_NONE, 0);
    // sum 3A, sent as "3a"
    body_text("GNVTG,Z");
    put_sentence(FLAW_LOWER, 0);
    body_text("GNRMC");
    put_sentence(FLAW_WRONG, 0);
    body_text("GNGGA");
    put_sentence(FLAW_ONE_DIGIT, 0);
    body_text("GNGGA");
    put_sentence(FLAW_NO_DIGIT, 0);
    // ends inside the body: drop the '*' too
    body_text("GNGGA,12");
    put_sentence(FLAW_NO_DIGIT, 0);
    void'(line_buf.pop_back());
    void'(line_buf.pop_back());
    line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    // NUL in the body
    body_text("GNGGA");
    body_buf.push_back(nlcc_pkg::CH_NUL);
    body_text("1");
    put_sentence(FLAW_NONE, 0);
    // top-bit bytes in the sum
    body_text("GN");
    body_buf.push_back(8'hFF);
    body_buf.push_back(8'h80);
    body_buf.push_back(8'hC3);
    put_sentence(FLAW_NONE, 0);
    // junk after the digits is ignored
    body_text("GNRMC,1");
    put_sentence(FLAW_NONE, 3);
    // '*' at the last legal index, then at the first illegal one, then far past it
    filler(SCAN_LIM - 2);
    put_sentence(FLAW_NONE, 0);
    filler(SCAN_LIM - 1);
    put_sentence(FLAW_NONE, 0);
    filler(SCAN_LIM + 15);
    put_sentence(FLAW_NONE, 0);
    // full store: the next byte ends the line and is lost, then an empty line
    line_buf.push_back(nlcc_pkg::CH_DOLLAR);
    repeat (LINE_BYTES - 1) line_buf.push_back(any_but_newline());
    line_buf.push_back(nlcc_pkg::CH_DOLLAR);
    line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    // full store closed by a newline
    repeat (LINE_BYTES) line_buf.push_back(any_but_newline());
    line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    flush_line();
  endtask

  // mostly well-formed sentences with random content, some noise and overfull lines
  task automatic random_line();
    int unsigned pick;
    int unsigned sel;
    int unsigned n;
    flaw_t       flaw;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(0, 30))
        line_buf.push_back(nlcc_pkg::byte_t'($urandom_range(0, 255)));
      line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    end else if (pick < 9) begin
      line_buf.push_back($urandom_range(0, 1) ? nlcc_pkg::CH_DOLLAR : any_but_newline());
      repeat (LINE_BYTES - 1 + $urandom_range(1, 3)) line_buf.push_back(any_but_newline());
      line_buf.push_back(nlcc_pkg::CH_NEWLINE);
    end else begin
      sel = $urandom_range(0, nlcc_pkg::NUM_KINDS - 1);
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          for (int k = 1; k < nlcc_pkg::PREFIX_LEN; k++)
            body_buf.push_back(nlcc_pkg::KIND_PREFIX[sel][k]);
        end
        3: begin
          for (int k = 1; k < nlcc_pkg::PREFIX_LEN; k++)
            body_buf.push_back(nlcc_pkg::KIND_PREFIX[sel][k]);
          body_buf[$urandom_range(0, nlcc_pkg::PREFIX_LEN - 2)] =
            nlcc_pkg::byte_t'($urandom_range(33, 126));
        end
        4: begin
          body_text("GP");
          filler(3);
        end
        default: ;
      endcase
      // one in ten runs up against the scan limit
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 78) : $urandom_range(0, 20);
      filler(n);
      if (body_buf.size() != 0 && $urandom_range(0, 24) == 0)
        body_buf[$urandom_range(0, body_buf.size() - 1)] = nlcc_pkg::CH_NUL;
      pick = $urandom_range(0, 99);
      if (pick < 80) flaw = FLAW_NONE;
      else if (pick < 86) flaw = FLAW_LOWER;
      else if (pick < 92) flaw = FLAW_WRONG;
      else if (pick < 96) flaw = FLAW_ONE_DIGIT;
      else flaw = FLAW_NO_DIGIT;
      put_sentence(flaw, ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0);
      if ($urandom_range(0, 49) == 0) line_buf[0] = any_but_newline();
    end
    flush_line();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("nmea_line_checksum_checker_tb: done, errors");
    $finish;
  end

  // result side: take verdicts, stall in random bursts
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_verdict(out_ch.line_valid, out_ch.sentence_kind, out_ch.computed_sum);
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // byte side and run control
  initial begin
    calm = 1'b0;
    board = new();
    random_sent = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_lines();
    wait_drained();

    // the directed lines count toward the total
    while (random_sent < RANDOM_BYTES) begin
      if (random_sent > RANDOM_BYTES * 85 / 100) calm = 1'b1;
      random_line();
      if (!calm && $urandom_range(0, 19) == 0) wait_drained();
    end

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // two-stage pipeline; spare edges to catch a stray verdict
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("nmea_line_checksum_checker_tb: done, clean");
    end else begin
      $display("nmea_line_checksum_checker_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/nlcc_pkg.sv
src/nlcc_in_if.sv
src/nlcc_out_if.sv
src/nlcc_step.sv
src/nmea_line_checksum_checker.sv
tb/sv/nmea_line_checksum_checker_tb.sv
